// File: rtl/rgbc_pkg.sv
// shared widths, constants and types of the color converter
`timescale 1ns / 1ps
`default_nettype none
package rgbc_pkg;

    // field widths
    localparam int CNT_W = 16;
    localparam int PCT_W = 7;
    localparam int HUE_W = 9;
    localparam int SUM_W = PCT_W + 1;

    // front divider: count*100 over clear, seven quotient bits
    localparam int FNUM_W = CNT_W + PCT_W;
    // back dividers: 60*diff over delta, 100*delta over saturation base
    localparam int BNUM_W = 14;
    localparam int BDEN_W = SUM_W;

    localparam int QUEUE_DEPTH_DEF = 4;

    // arithmetic constants
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] LIG_SPLIT = 7'd50;
    localparam logic [SUM_W-1:0] SUM_FULL  = 8'd200;
    localparam logic [HUE_W-1:0] HUE_120   = 9'd120;
    localparam logic [HUE_W-1:0] HUE_240   = 9'd240;
    localparam logic [HUE_W-1:0] HUE_360   = 9'd360;

    // sector holding the largest channel
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // classified sample handed from front to back
    typedef struct packed {
        logic             ok;
        t_sector          sector;
        logic             neg;
        logic [PCT_W-1:0] mag;
        logic [PCT_W-1:0] mx;
        logic [PCT_W-1:0] mn;
    } t_cls;

    // queue write or head: valid flag with its entry
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_push;

endpackage
`default_nettype wire

// File: rtl/rgbc_if.sv
// input and output channel interfaces of the color converter
`timescale 1ns / 1ps
`default_nettype none
interface rgbc_in_if;
    import rgbc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] red_count;
    logic [CNT_W-1:0] green_count;
    logic [CNT_W-1:0] blue_count;
    logic [CNT_W-1:0] clear_count;

    modport source (output valid, red_count, green_count, blue_count, clear_count,
                    input ready);
    modport sink   (input valid, red_count, green_count, blue_count, clear_count,
                    output ready);
endinterface

interface rgbc_out_if;
    import rgbc_pkg::*;
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_degrees;
    logic [PCT_W-1:0] saturation_pct;
    logic [PCT_W-1:0] lightness_pct;
    logic             result_ok;

    modport source (output valid, hue_degrees, saturation_pct, lightness_pct, result_ok,
                    input ready);
    modport sink   (input valid, hue_degrees, saturation_pct, lightness_pct, result_ok,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/rgbc_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
`timescale 1ns / 1ps
`default_nettype none
module rgbc_div #(
    parameter int L  = 1,
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 4,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [L-1:0][NW-1:0]   i_num,
    input  logic [L-1:0][DW-1:0]   i_den,
    input  logic [SW-1:0]          i_sb,
    output logic                   o_valid,
    output logic [L-1:0][QW-1:0]   o_quo,
    output logic [SW-1:0]          o_sb
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW-1:0]                  r_valid;
    logic [QW-1:0]                  w_valid_in;
    logic [QW-1:0][L-1:0][CW-1:0]   r_rem, n_rem, w_rem_in;
    logic [QW-1:0][L-1:0][DW-1:0]   r_den, w_den_in;
    logic [QW-1:0][L-1:0][QW-1:0]   r_quo, n_quo, w_quo_in;
    logic [QW-1:0][SW-1:0]          r_sb, w_sb_in;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        // stage inputs: ports for the first stage, previous registers after
        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < L; l++) begin
                    w_rem_in[0][l] = CW'(i_num[l]);
                end
            end
            assign w_den_in[0]   = i_den;
            assign w_quo_in[0]   = '0;
            assign w_sb_in[0]    = i_sb;
            assign w_valid_in[0] = i_valid;
        end else begin : g_next
            assign w_rem_in[s]   = r_rem[s-1];
            assign w_den_in[s]   = r_den[s-1];
            assign w_quo_in[s]   = r_quo[s-1];
            assign w_sb_in[s]    = r_sb[s-1];
            assign w_valid_in[s] = r_valid[s-1];
        end

        // trial subtract of the shifted divisor
        always_comb begin
            logic [CW-1:0] v_sh;
            for (int l = 0; l < L; l++) begin
                v_sh = CW'(w_den_in[s][l]) << B;
                if (w_rem_in[s][l] >= v_sh) begin
                    n_rem[s][l] = w_rem_in[s][l] - v_sh;
                    n_quo[s][l] = w_quo_in[s][l] | (QW'(1) << B);
                end else begin
                    n_rem[s][l] = w_rem_in[s][l];
                    n_quo[s][l] = w_quo_in[s][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid_in[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_den_in[s];
                r_quo[s] <= n_quo[s];
                r_sb[s]  <= w_sb_in[s];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_sb    = r_sb[QW-1];
endmodule
`default_nettype wire

// File: rtl/rgbc_front.sv
// front end: accepts samples, scales to percent of clear, finds max, min and sector
`timescale 1ns / 1ps
`default_nettype none
module rgbc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rgbc_in_if.sink         i_in,
    input  logic            i_q_ready,
    output rgbc_pkg::t_push o_push
);
    import rgbc_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [2:0] over;
    } t_fsb;

    logic                          w_en;
    logic [2:0][CNT_W-1:0]         w_cnt;
    logic [2:0][FNUM_W-1:0]        w_num;
    logic [2:0][CNT_W-1:0]         w_den;
    t_fsb                          w_sb_in, w_sb_out;
    logic                          w_div_valid;
    logic [2:0][PCT_W-1:0]         w_quo;
    logic [2:0][PCT_W-1:0]         w_pct;

    logic                          r_valid;
    logic                          r_ok;
    logic [2:0][PCT_W-1:0]         r_pct;

    // the whole front moves together unless its last stage is blocked
    assign w_en       = !r_valid || i_q_ready;
    assign i_in.ready = w_en;

    assign w_cnt[0] = i_in.red_count;
    assign w_cnt[1] = i_in.green_count;
    assign w_cnt[2] = i_in.blue_count;

    // count*100 by shift and add, over-range flag when quotient would pass 127
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_num[l] = (FNUM_W'(w_cnt[l]) << 6) + (FNUM_W'(w_cnt[l]) << 5)
                     + (FNUM_W'(w_cnt[l]) << 2);
            w_den[l] = i_in.clear_count;
            w_sb_in.over[l] = w_num[l][FNUM_W-1:PCT_W] >= i_in.clear_count;
        end
        w_sb_in.ok = i_in.clear_count != '0;
    end

    rgbc_div #(
        .L  (3),
        .NW (FNUM_W),
        .DW (CNT_W),
        .QW (PCT_W),
        .SW ($bits(t_fsb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_sb    (w_sb_in),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_sb    (w_sb_out)
    );

    // clamp at 100 percent
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_pct[l] = (w_sb_out.over[l] || w_quo[l] > PCT_MAX) ? PCT_MAX : w_quo[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok  <= w_sb_out.ok;
            r_pct <= w_pct;
        end
    end

    // max, min and sector, red wins ties over green, green over blue
    always_comb begin
        logic [PCT_W-1:0] v_mx, v_mn, v_a, v_b;
        t_sector          v_sec;
        v_mx = r_pct[0];
        if (r_pct[1] > v_mx) v_mx = r_pct[1];
        if (r_pct[2] > v_mx) v_mx = r_pct[2];
        v_mn = r_pct[0];
        if (r_pct[1] < v_mn) v_mn = r_pct[1];
        if (r_pct[2] < v_mn) v_mn = r_pct[2];
        if (v_mx == r_pct[0]) begin
            v_sec = SEC_RED;
            v_a   = r_pct[1];
            v_b   = r_pct[2];
        end else if (v_mx == r_pct[1]) begin
            v_sec = SEC_GREEN;
            v_a   = r_pct[2];
            v_b   = r_pct[0];
        end else begin
            v_sec = SEC_BLUE;
            v_a   = r_pct[0];
            v_b   = r_pct[1];
        end
        o_push.valid      = r_valid;
        o_push.cls.ok     = r_ok;
        o_push.cls.sector = v_sec;
        o_push.cls.neg    = v_a < v_b;
        o_push.cls.mag    = (v_a < v_b) ? v_b - v_a : v_a - v_b;
        o_push.cls.mx     = v_mx;
        o_push.cls.mn     = v_mn;
    end
endmodule
`default_nettype wire

// File: rtl/rgbc_queue.sv
// small register queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module rgbc_queue #(
    parameter int DEPTH = rgbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rgbc_pkg::t_push i_push,
    output logic            o_ready,
    output rgbc_pkg::t_push o_head,
    input  logic            i_pop
);
    import rgbc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_ready    = r_cnt != CW'(DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.cls = r_mem[r_rd];
    assign w_wr       = i_push.valid && o_ready;
    assign w_rd       = i_pop && o_head.valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_rd) r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (!w_wr && w_rd) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr] <= i_push.cls;
    end
endmodule
`default_nettype wire

// File: rtl/rgbc_back.sv
// back end: hue and saturation division, result register
`timescale 1ns / 1ps
`default_nettype none
module rgbc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rgbc_pkg::t_push i_head,
    output logic            o_pop,
    rgbc_out_if.source      o_out
);
    import rgbc_pkg::*;

    typedef struct packed {
        logic             ok;
        logic             gray;
        logic [PCT_W-1:0] lig;
        t_sector          sector;
        logic             neg;
    } t_bsb;

    logic                       w_en;
    logic [PCT_W-1:0]           w_delta;
    logic [SUM_W-1:0]           w_sum;
    logic [1:0][BNUM_W-1:0]     w_num;
    logic [1:0][BDEN_W-1:0]     w_den;
    t_bsb                       w_sb_in, w_sb_out;
    logic                       w_div_valid;
    logic [1:0][PCT_W-1:0]      w_quo;
    logic [HUE_W-1:0]           w_hue;

    logic                       r_valid;
    logic [HUE_W-1:0]           r_hue;
    logic [PCT_W-1:0]           r_sat;
    logic [PCT_W-1:0]           r_lig;
    logic                       r_ok;

    assign w_en  = !r_valid || o_out.ready;
    assign o_pop = i_head.valid && w_en;

    // delta, sum, lightness and the two division operands
    always_comb begin
        w_delta = i_head.cls.mx - i_head.cls.mn;
        w_sum   = SUM_W'(i_head.cls.mx) + SUM_W'(i_head.cls.mn);
        w_sb_in.ok     = i_head.cls.ok;
        w_sb_in.gray   = w_delta == '0;
        w_sb_in.lig    = w_sum[SUM_W-1:1];
        w_sb_in.sector = i_head.cls.sector;
        w_sb_in.neg    = i_head.cls.neg;
        w_num[0] = (BNUM_W'(i_head.cls.mag) << 6) - (BNUM_W'(i_head.cls.mag) << 2);
        w_den[0] = BDEN_W'(w_delta);
        w_num[1] = (BNUM_W'(w_delta) << 6) + (BNUM_W'(w_delta) << 5)
                 + (BNUM_W'(w_delta) << 2);
        w_den[1] = (w_sum[SUM_W-1:1] <= LIG_SPLIT) ? w_sum : SUM_FULL - w_sum;
    end

    rgbc_div #(
        .L  (2),
        .NW (BNUM_W),
        .DW (BDEN_W),
        .QW (PCT_W),
        .SW ($bits(t_bsb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_head.valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_sb    (w_sb_in),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_sb    (w_sb_out)
    );

    // sector offset, truncated term taken with its sign
    always_comb begin
        logic [HUE_W-1:0] v_q;
        v_q = HUE_W'(w_quo[0]);
        unique case (w_sb_out.sector)
            SEC_RED:   w_hue = w_sb_out.neg ? HUE_360 - v_q : v_q;
            SEC_GREEN: w_hue = w_sb_out.neg ? HUE_120 - v_q : HUE_120 + v_q;
            SEC_BLUE:  w_hue = w_sb_out.neg ? HUE_240 - v_q : HUE_240 + v_q;
            default:   w_hue = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_div_valid;
        end
    end

    // result register, zero fields for an invalid sample, zero hue and sat for gray
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok  <= w_sb_out.ok;
            r_lig <= w_sb_out.ok ? w_sb_out.lig : '0;
            r_hue <= (w_sb_out.ok && !w_sb_out.gray) ? w_hue : '0;
            r_sat <= (w_sb_out.ok && !w_sb_out.gray) ? w_quo[1] : '0;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.hue_degrees    = r_hue;
    assign o_out.saturation_pct = r_sat;
    assign o_out.lightness_pct  = r_lig;
    assign o_out.result_ok      = r_ok;
endmodule
`default_nettype wire

// File: rtl/rgbc_to_hsl_converter.sv
// registers from input transaction to result, queue empty: 7 divide stages,
//   the first loading at the accepting edge, and the clamp register in front, one
//   queue write, 7 divide stages and the result register in back
// throughput: one transaction per cycle while the receiver is ready, set by the bit-per-stage pipelined dividers
// the queue between front and back holds QUEUE_DEPTH entries
// reset: synchronous active low, clears all valid flags and queue pointers
`timescale 1ns / 1ps
`default_nettype none
module rgbc_to_hsl_converter #(
    parameter int QUEUE_DEPTH = rgbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbc_in_if.sink     i_in,
    rgbc_out_if.source  o_out
);
    import rgbc_pkg::*;

    t_push w_push;
    t_push w_head;
    logic  w_q_ready;
    logic  w_pop;

    rgbc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push)
    );

    rgbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    rgbc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // an invalid sample carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.result_ok |->
            o_out.hue_degrees == '0 && o_out.saturation_pct == '0 &&
            o_out.lightness_pct == '0)
        else $error("invalid result with nonzero fields");

    // results stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.hue_degrees <= HUE_360 &&
            o_out.saturation_pct <= PCT_MAX && o_out.lightness_pct <= PCT_MAX)
        else $error("result field out of range");

    // the front only stalls when the queue is full and its last stage holds data
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> !w_q_ready && w_push.valid)
        else $error("front stalled without a full queue");

    // the back pops only a present entry
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from an empty queue");
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// self-checking testbench of the rgbc to hsl color converter
`timescale 1ns / 1ps
`default_nettype none

// expected hsl results of accepted color samples, oldest first
class hsl_scoreboard;
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lig;
        logic       ok;
    } t_hsl;

    t_hsl pending_hsl[$];
    int   mismatch_cnt;

    // scale a count to a clamped percent of clear
    static function int unsigned scale_pct(int unsigned cnt, int unsigned clr);
        int unsigned p;
        p = (cnt * 100) / clr;
        return (p > 100) ? 100 : p;
    endfunction

    // note one accepted color sample and work out its hsl
    function void note_sample(logic [15:0] r_c, logic [15:0] g_c, logic [15:0] b_c,
                              logic [15:0] c_c);
        t_hsl        h;
        int unsigned r, g, b, mx, mn, dif, sum, lig, sat;
        int          hue;
        h = '0;
        if (c_c != 0) begin
            r = scale_pct(r_c, c_c);
            g = scale_pct(g_c, c_c);
            b = scale_pct(b_c, c_c);
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            dif = mx - mn;
            sum = mx + mn;
            lig = sum / 2;
            hue = 0;
            sat = 0;
            if (dif != 0) begin
                // ties for maximum: red, then green, then blue
                if (mx == r) begin
                    hue = (60 * (int'(g) - int'(b))) / int'(dif);
                    if (g < b) hue += 360;
                end else if (mx == g) begin
                    hue = (60 * (int'(b) - int'(r))) / int'(dif) + 120;
                end else begin
                    hue = (60 * (int'(r) - int'(g))) / int'(dif) + 240;
                end
                if (lig <= 50) sat = (dif * 100) / sum;
                else sat = (dif * 100) / (200 - sum);
            end
            h.hue = hue[8:0];
            h.sat = sat[6:0];
            h.lig = lig[6:0];
            h.ok  = 1'b1;
        end
        pending_hsl.push_back(h);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_cnt++;
    endtask

    // check one result against the oldest expectation
    task automatic check_result(logic [8:0] hue, logic [6:0] sat, logic [6:0] lig,
                                logic ok);
        t_hsl w;
        if (pending_hsl.size() == 0) begin
            report("unexpected result", 1, 0);
        end else begin
            w = pending_hsl.pop_front();
            if (hue !== w.hue) report("hue_degrees", hue, w.hue);
            if (sat !== w.sat) report("saturation_pct", sat, w.sat);
            if (lig !== w.lig) report("lightness_pct", lig, w.lig);
            if (ok !== w.ok) report("result_ok", ok, w.ok);
        end
    endtask
endclass

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rgbc_in_if  in_ch ();
    rgbc_out_if out_ch ();

    rgbc_to_hsl_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    hsl_scoreboard sb = new();
    int  idle_pct_in = 29;
    int  idle_pct_out = 29;
    bit  hold_sink = 1'b0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.red_count = '0;
        in_ch.green_count = '0;
        in_ch.blue_count = '0;
        in_ch.clear_count = '0;
        out_ch.ready = 1'b0;
    end

    // accept monitor and result checker at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.red_count, in_ch.green_count, in_ch.blue_count,
                               in_ch.clear_count);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.hue_degrees, out_ch.saturation_pct,
                                out_ch.lightness_pct, out_ch.result_ok);
        end
    end

    // receiver ready with random stalls and a forced hold-off
    always @(negedge i_clk) begin
        if (hold_sink) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= idle_pct_out);
    end

    // send one color transaction, idling at random first; valid stays high afterwards
    task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                               logic [15:0] c);
        while ($urandom_range(99) < idle_pct_in) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.red_count <= r;
        in_ch.green_count <= g;
        in_ch.blue_count <= b;
        in_ch.clear_count <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending_hsl.size() != 0) @(negedge i_clk);
    endtask

    // random color sample, mostly with clear near the color counts
    task automatic send_random();
        logic [15:0] c;
        int          mode;
        mode = $urandom_range(9);
        if (mode == 0) c = 16'($urandom);
        else if (mode == 1) c = 16'($urandom_range(3));
        else c = 16'($urandom_range(1000, 1));
        if (mode == 0)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), c);
        else
            send_sample(16'($urandom_range(c + c / 4)), 16'($urandom_range(c + c / 4)),
                        16'($urandom_range(c + c / 4)), c);
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero clear, clamp, gray, ties, sectors
        send_sample(16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'd50, 16'd50, 16'd50, 16'd100);
        send_sample(16'hFFFF, 16'd0, 16'd0, 16'd1);
        send_sample(16'd0, 16'hFFFF, 16'd0, 16'd1);
        send_sample(16'd0, 16'd0, 16'hFFFF, 16'd1);
        send_sample(16'd100, 16'd100, 16'd0, 16'd100);
        send_sample(16'd0, 16'd100, 16'd100, 16'd100);
        send_sample(16'd100, 16'd0, 16'd100, 16'd100);
        send_sample(16'd100, 16'd0, 16'd1, 16'd100);
        send_sample(16'd100, 16'd20, 16'd50, 16'd100);
        send_sample(16'd30, 16'd90, 16'd10, 16'd100);
        send_sample(16'd30, 16'd10, 16'd90, 16'd100);
        send_sample(16'd60, 16'd40, 16'd45, 16'd100);
        send_sample(16'd1, 16'd2, 16'd3, 16'd100);
        send_sample(16'd99, 16'd98, 16'd97, 16'd100);
        send_sample(16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555, 16'hEDCB, 16'h5555);

        // long stall-free stretch
        idle_pct_in = 0;
        idle_pct_out = 0;
        repeat (150) send_random();

        // receiver holds off while the sender keeps offering
        idle_pct_in = 29;
        idle_pct_out = 29;
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            repeat (40) send_random();
        join

        // sender pauses until everything has come out
        wait_drained();
        repeat (900) send_random();

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (sb.mismatch_cnt == 0 && sb.pending_hsl.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// File: rgbc_to_hsl_converter.f
rtl/rgbc_pkg.sv
rtl/rgbc_if.sv
rtl/rgbc_div.sv
rtl/rgbc_front.sv
rtl/rgbc_queue.sv
rtl/rgbc_back.sv
rtl/rgbc_to_hsl_converter.sv
bench/tb_top.sv
